// File: rtl/sorted_membership_table_macros.svh
// Assertion macros shared by the sorted membership table RTL.
`ifndef SORTED_MEMBERSHIP_TABLE_MACROS_SVH
`define SORTED_MEMBERSHIP_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define SMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define SMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define SMT_ASSERT(lbl, prop, msg)
`define SMT_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// File: rtl/smt_pkg.sv
// Package with the shared types and constants of the sorted membership table.
package smt_pkg;

  // Request kinds carried on the input tuser.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam int unsigned KEY_W         = 32;
  localparam int unsigned ENTRY_COUNT_W = 9;
  localparam int unsigned OUT_TDATA_W   = 16;

  // Control flags of a request travelling along the cell chain.
  typedef struct packed {
    logic vld;      // stage holds a request
    logic query;    // membership query rather than a load
    logic live;     // a load whose value still looks for its place
    logic dropped;  // load refused because the table was full
    logic found;    // query matched a stored value so far
  } smt_flags_t;

endpackage

// File: rtl/smt_cell.sv
// One cell of the chain: holds a single table entry and passes requests on.
module smt_cell #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned COUNT_W     = 9,
  parameter int unsigned CELL_INDEX  = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  smt_pkg::smt_flags_t           flags_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  input  logic [COUNT_W-1:0]            cnt_i,
  output smt_pkg::smt_flags_t           flags_o,
  output logic signed [VALUE_WIDTH-1:0] key_o,
  output logic [COUNT_W-1:0]            cnt_o
);
  import smt_pkg::*;

  logic signed [VALUE_WIDTH-1:0] val_q, val_d;
  smt_flags_t                    flags_q, flags_d;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d;
  logic [COUNT_W-1:0]            cnt_q;
  logic                          occupied;

  // The request carries the entry count from before it, so the cell knows
  // whether its entry was written without a valid bit of its own.
  assign occupied = (cnt_i > COUNT_W'(CELL_INDEX));

  always_comb begin
    flags_d = flags_i;
    key_d   = key_i;
    val_d   = val_q;
    if (flags_i.vld && !flags_i.query && flags_i.live) begin
      if (!occupied) begin
        val_d        = key_i;
        flags_d.live = 1'b0;
      end else if (val_q > key_i) begin
        // Take the new value and push the larger one further down.
        val_d = key_i;
        key_d = val_q;
      end
    end
    if (flags_i.vld && flags_i.query && occupied && (val_q == key_i)) begin
      flags_d.found = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      key_q <= key_d;
      cnt_q <= cnt_i;
    end
  end

  assign flags_o = flags_q;
  assign key_o   = key_q;
  assign cnt_o   = cnt_q;

endmodule

// File: rtl/sorted_membership_table.sv
// Sorted membership table: a chain of compare-and-shift cells.
//
// Input channel s_axis: one request per transfer. tuser selects load (0) or
// query (1), tdata carries the signed value. A load inserts the value in
// ascending order, duplicates kept; a load into a full table is refused.
// A query reports whether the value is stored.
// Output channel m_axis: exactly one result per request, in request order,
// with found, dropped and the entry count after the request.
// Each request walks the chain of TABLE_DEPTH cells, each of which registers it,
// and then the output register, which holds the result. The chain is fully
// pipelined and takes one request per cycle while the output is drained.
// Reset empties the chain and sets the entry count to zero. When the
// receiver stalls with a result waiting, the whole chain holds and
// s_axis_tready_o falls until the result is taken.
module sorted_membership_table #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [smt_pkg::KEY_W-1:0]          s_axis_tdata_i,  // [31:0] key_value
  input  logic                               s_axis_tuser_i,  // [0] func
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] found, [1] dropped, [10:2] entry_count, [15:11] zero
  output logic [smt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import smt_pkg::*;

`include "sorted_membership_table_macros.svh"

  localparam int unsigned COUNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PAD_W   = OUT_TDATA_W - ENTRY_COUNT_W - 2;

  logic                          en;
  logic                          accept;
  logic                          full;
  logic [COUNT_W-1:0]            count_q, count_d;
  logic signed [KEY_W-1:0]       key_in;

  smt_flags_t                    flags_chain [TABLE_DEPTH+1];
  logic signed [VALUE_WIDTH-1:0] key_chain   [TABLE_DEPTH];
  logic [COUNT_W-1:0]            cnt_chain   [TABLE_DEPTH+1];

  logic                          out_vld_q;
  logic                          out_found_q;
  logic                          out_drop_q;
  logic [COUNT_W-1:0]            out_cnt_q;
  logic [COUNT_W-1:0]            last_cnt_after;

  // The chain advances whenever the output register can take its result.
  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;
  assign full            = (count_q == COUNT_W'(TABLE_DEPTH));
  assign key_in          = $signed(s_axis_tdata_i);

  always_comb begin
    flags_chain[0]         = '0;
    flags_chain[0].vld     = accept;
    flags_chain[0].query   = (s_axis_tuser_i == FUNC_QUERY);
    flags_chain[0].live    = (s_axis_tuser_i == FUNC_LOAD) && !full;
    flags_chain[0].dropped = (s_axis_tuser_i == FUNC_LOAD) && full;
    key_chain[0]           = VALUE_WIDTH'(key_in);
    cnt_chain[0]           = count_q;
  end

  always_comb begin
    count_d = count_q;
    if (accept && (s_axis_tuser_i == FUNC_LOAD) && !full) begin
      count_d = count_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g < TABLE_DEPTH - 1) begin : g_mid
      smt_cell #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_W     (COUNT_W),
        .CELL_INDEX  (g)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .flags_i (flags_chain[g]),
        .key_i   (key_chain[g]),
        .cnt_i   (cnt_chain[g]),
        .flags_o (flags_chain[g+1]),
        .key_o   (key_chain[g+1]),
        .cnt_o   (cnt_chain[g+1])
      );
    end else begin : g_last
      // Nothing follows the last cell, so its outgoing value is not needed.
      smt_cell #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .COUNT_W     (COUNT_W),
        .CELL_INDEX  (g)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .flags_i (flags_chain[g]),
        .key_i   (key_chain[g]),
        .cnt_i   (cnt_chain[g]),
        .flags_o (flags_chain[g+1]),
        .key_o   (),
        .cnt_o   (cnt_chain[g+1])
      );
    end
  end

  // A load that was taken adds one entry to the count it carried.
  assign last_cnt_after = cnt_chain[TABLE_DEPTH] +
      COUNT_W'(!flags_chain[TABLE_DEPTH].query && !flags_chain[TABLE_DEPTH].dropped);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= flags_chain[TABLE_DEPTH].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_found_q <= flags_chain[TABLE_DEPTH].query && flags_chain[TABLE_DEPTH].found;
      out_drop_q  <= !flags_chain[TABLE_DEPTH].query && flags_chain[TABLE_DEPTH].dropped;
      out_cnt_q   <= last_cnt_after;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, ENTRY_COUNT_W'(out_cnt_q), out_drop_q, out_found_q};

  `SMT_ASSERT(a_count_bounded, count_q <= COUNT_W'(TABLE_DEPTH),
    "entry count exceeds the table depth")
  `SMT_ASSERT(a_load_placed,
    flags_chain[TABLE_DEPTH].vld && !flags_chain[TABLE_DEPTH].query |->
      !flags_chain[TABLE_DEPTH].live,
    "an accepted load left the chain without a place")
  `SMT_ASSERT(a_count_step,
    accept && (s_axis_tuser_i == FUNC_LOAD) && !full |=> count_q == $past(count_q) + COUNT_W'(1),
    "accepted load did not advance the entry count")
  `SMT_ASSERT(a_result_flags,
    out_vld_q |-> !(out_found_q && out_drop_q),
    "result flags both found and dropped")

endmodule
